FILE: rtl/trhs_pkg.sv
// Shared types and constants for the torque ramp/hold sequencer.
package trhs_pkg;

    localparam int TORQUE_W  = 16;
    localparam int ELAPSED_W = 17;
    localparam int SINCE_W   = 8;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 24;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [SINCE_W-1:0]   SINCE_MAX   = '1;
    localparam logic [CNT_W-1:0]     DIV_LAST    = '1;
    localparam logic [63:0]          PAYLOAD_ALL = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0]          PAYLOAD_HI  = 32'hFFFF_FFFF;
    localparam logic [15:0]          PAYLOAD_LO  = 16'hFFFF;

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_TRIGGER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_PERIOD_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_DIVISOR  = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RAMP = 2'd1,
        PH_HOLD = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_LOAD,
        ST_DIV,
        ST_PACK,
        ST_FRAME,
        ST_ZERO
    } state_t;

    typedef struct packed {
        logic load_trigger;
        logic advance;
        logic start;
        logic div_load;
        logic div_step;
        logic pack;
        logic load_zero;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic send_due;
        logic div_last;
        logic two_frames;
    } sts_t;

endpackage

FILE: rtl/trhs_ctrl.sv
// Sequencer controller: handshakes and command sequencing for the datapath.
module trhs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             req_type,
    output logic             out_valid,
    input  logic             out_ready,
    input  trhs_pkg::sts_t   sts,
    output trhs_pkg::cmd_t   cmd
);

    trhs_pkg::state_t state_reg;
    trhs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trhs_pkg::ST_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            trhs_pkg::ST_WAIT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == trhs_pkg::REQ_TRIGGER)
                    begin
                        cmd.load_trigger = 1'b1;
                    end
                    else if (sts.active)
                    begin
                        if (sts.send_due)
                        begin
                            cmd.start  = 1'b1;
                            state_next = trhs_pkg::ST_LOAD;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                end
            end
            trhs_pkg::ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = trhs_pkg::ST_DIV;
            end
            trhs_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = trhs_pkg::ST_PACK;
                end
            end
            trhs_pkg::ST_PACK:
            begin
                cmd.pack   = 1'b1;
                state_next = trhs_pkg::ST_FRAME;
            end
            trhs_pkg::ST_FRAME:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.two_frames)
                    begin
                        cmd.load_zero = 1'b1;
                        state_next    = trhs_pkg::ST_ZERO;
                    end
                    else
                    begin
                        state_next = trhs_pkg::ST_WAIT;
                    end
                end
            end
            trhs_pkg::ST_ZERO:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = trhs_pkg::ST_WAIT;
                end
            end
            default:
            begin
                state_next = trhs_pkg::ST_WAIT;
            end
        endcase
    end

endmodule

FILE: rtl/trhs_dpath.sv
// Sequencer datapath: config registers, phase counters, scaling and bit-serial divider.
module trhs_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  trhs_pkg::cmd_t                      cmd,
    output trhs_pkg::sts_t                      sts,
    input  logic                                cfg_we,
    input  logic [trhs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trhs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [trhs_pkg::TORQUE_W-1:0]       torque_milli,
    input  logic [15:0]                         hold_ms,
    output logic [63:0]                         payload,
    output logic [1:0]                          phase_after,
    output logic                                last_of_run
);

    // configuration
    logic [15:0] ramp_ms_reg;
    logic [7:0]  tx_period_ms_reg;
    logic [15:0] torque_limit_reg;
    logic [15:0] hold_limit_reg;
    logic [15:0] raw_offset_reg;
    logic [7:0]  res_divisor_reg;

    // sequence state
    trhs_pkg::phase_t                 phase_reg;
    logic [trhs_pkg::ELAPSED_W-1:0]   elapsed_reg;
    logic [trhs_pkg::SINCE_W-1:0]     since_reg;
    logic                             forced_reg;
    logic [15:0]                      target_reg;
    logic [15:0]                      hold_len_reg;

    // frame job
    logic [trhs_pkg::NUM_W-1:0]       num_reg;
    logic [trhs_pkg::DEN_W-1:0]       den_reg;
    logic                             two_reg;
    trhs_pkg::phase_t                 first_phase_reg;
    logic                             first_last_reg;

    // divider
    logic [trhs_pkg::DEN_W-1:0]       rem_reg;
    logic [trhs_pkg::NUM_W-1:0]       quo_reg;
    logic [trhs_pkg::CNT_W-1:0]       cnt_reg;

    // output
    logic [63:0]                      payload_reg;
    trhs_pkg::phase_t                 phase_after_reg;
    logic                             last_reg;

    logic [15:0]                      ramp_eff;
    logic [7:0]                       div_eff;
    logic                             is_ramp;
    logic                             ramp_done;
    logic                             hold_expire;
    logic [15:0]                      e_sel;
    logic [15:0]                      mul_a;
    logic [15:0]                      mul_r;
    logic [trhs_pkg::NUM_W-1:0]       num_next;
    logic [trhs_pkg::DEN_W-1:0]       den_next;
    logic [trhs_pkg::ELAPSED_W-1:0]   elapsed_inc;
    logic [trhs_pkg::SINCE_W-1:0]     since_inc;
    logic [trhs_pkg::DEN_W:0]         trial;
    logic                             fits;
    logic [trhs_pkg::NUM_W:0]         raw_sum;
    logic                             frame_ok;

    assign ramp_eff    = (ramp_ms_reg == 16'd0) ? 16'd1 : ramp_ms_reg;
    assign div_eff     = (res_divisor_reg == 8'd0) ? 8'd1 : res_divisor_reg;
    assign is_ramp     = (phase_reg == trhs_pkg::PH_RAMP);
    assign ramp_done   = (elapsed_reg >= {1'b0, ramp_eff});
    assign hold_expire = (elapsed_reg >= {1'b0, hold_len_reg});
    assign e_sel       = ramp_done ? ramp_eff : elapsed_reg[15:0];

    // hold frames scale by 1/1
    assign mul_a    = is_ramp ? e_sel : 16'd1;
    assign mul_r    = is_ramp ? ramp_eff : 16'd1;
    assign num_next = {16'd0, target_reg} * {16'd0, mul_a};
    assign den_next = {8'd0, mul_r} * {16'd0, div_eff};

    assign elapsed_inc = (elapsed_reg == trhs_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                : elapsed_reg + 1'b1;
    assign since_inc   = (since_reg == trhs_pkg::SINCE_MAX) ? since_reg : since_reg + 1'b1;

    assign trial = {rem_reg, quo_reg[trhs_pkg::NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    assign raw_sum  = {1'b0, quo_reg} + {{(trhs_pkg::NUM_W-15){1'b0}}, raw_offset_reg};
    assign frame_ok = (num_reg != '0) && (raw_sum[trhs_pkg::NUM_W:16] == '0);

    assign sts.active     = (phase_reg != trhs_pkg::PH_IDLE);
    assign sts.send_due   = forced_reg || (since_reg >= tx_period_ms_reg);
    assign sts.div_last   = (cnt_reg == trhs_pkg::DIV_LAST);
    assign sts.two_frames = two_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_ms_reg      <= 16'd5000;
            tx_period_ms_reg <= 8'd10;
            torque_limit_reg <= 16'd8000;
            hold_limit_reg   <= 16'd30000;
            raw_offset_reg   <= 16'd32127;
            res_divisor_reg  <= 8'd15;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trhs_pkg::CFG_RAMP_MS:      ramp_ms_reg      <= cfg_data;
                trhs_pkg::CFG_TX_PERIOD_MS: tx_period_ms_reg <= cfg_data[7:0];
                trhs_pkg::CFG_TORQUE_LIMIT: torque_limit_reg <= cfg_data;
                trhs_pkg::CFG_HOLD_LIMIT:   hold_limit_reg   <= cfg_data;
                trhs_pkg::CFG_RAW_OFFSET:   raw_offset_reg   <= cfg_data;
                trhs_pkg::CFG_RES_DIVISOR:  res_divisor_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Counter updates for a sending tick are applied at start; the frame
    // operands are captured from the pre-update state in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= trhs_pkg::PH_IDLE;
            elapsed_reg  <= '0;
            since_reg    <= '0;
            forced_reg   <= 1'b0;
            target_reg   <= '0;
            hold_len_reg <= '0;
            two_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.load_trigger)
            begin
                target_reg   <= (torque_milli < torque_limit_reg) ? torque_milli
                                                                  : torque_limit_reg;
                hold_len_reg <= (hold_ms < hold_limit_reg) ? hold_ms : hold_limit_reg;
                phase_reg    <= trhs_pkg::PH_RAMP;
                elapsed_reg  <= '0;
                since_reg    <= '0;
                forced_reg   <= 1'b1;
            end
            else if (cmd.advance)
            begin
                elapsed_reg <= elapsed_inc;
                since_reg   <= since_inc;
            end
            else if (cmd.start)
            begin
                forced_reg <= 1'b0;
                two_reg    <= !is_ramp && hold_expire;
                if (is_ramp)
                begin
                    since_reg <= {{(trhs_pkg::SINCE_W-1){1'b0}}, 1'b1};
                    if (ramp_done)
                    begin
                        phase_reg   <= trhs_pkg::PH_HOLD;
                        elapsed_reg <= {{(trhs_pkg::ELAPSED_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        elapsed_reg <= elapsed_inc;
                    end
                end
                else if (hold_expire)
                begin
                    phase_reg <= trhs_pkg::PH_IDLE;
                    since_reg <= '0;
                end
                else
                begin
                    since_reg   <= {{(trhs_pkg::SINCE_W-1){1'b0}}, 1'b1};
                    elapsed_reg <= elapsed_inc;
                end
            end

            if (cmd.div_load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            num_reg         <= num_next;
            den_reg         <= den_next;
            first_last_reg  <= is_ramp || !hold_expire;
            first_phase_reg <= (is_ramp && !ramp_done) ? trhs_pkg::PH_RAMP
                                                       : trhs_pkg::PH_HOLD;
        end

        // restoring division, one quotient bit per cycle
        if (cmd.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= num_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? trial[trhs_pkg::DEN_W-1:0] - den_reg
                            : trial[trhs_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[trhs_pkg::NUM_W-2:0], fits};
        end

        if (cmd.pack)
        begin
            payload_reg     <= frame_ok ? {trhs_pkg::PAYLOAD_HI, raw_sum[15:0],
                                           trhs_pkg::PAYLOAD_LO}
                                        : trhs_pkg::PAYLOAD_ALL;
            phase_after_reg <= first_phase_reg;
            last_reg        <= first_last_reg;
        end
        else if (cmd.load_zero)
        begin
            payload_reg     <= trhs_pkg::PAYLOAD_ALL;
            phase_after_reg <= trhs_pkg::PH_IDLE;
            last_reg        <= 1'b1;
        end
    end

    assign payload     = payload_reg;
    assign phase_after = phase_after_reg;
    assign last_of_run = last_reg;

endmodule

FILE: rtl/torque_ramp_hold_sequencer.sv
// Torque ramp/hold command sequencer top level.
// Triggers and ticks that send no frame are taken in the wait state, which they do not leave.
// A sending tick: after accept come load, a 32-step divide (the divider dominates) and pack
// before the first frame is valid; the next item is taken once the last frame is accepted.
// On hold expiry a second zero frame follows the first, each held valid until accepted.
// rst_n clears state to idle and loads the configuration defaults.
module torque_ramp_hold_sequencer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [trhs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trhs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [15:0]                         torque_milli,
    input  logic [15:0]                         hold_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [63:0]                         payload,
    output logic [1:0]                          phase_after,
    output logic                                last_of_run
);

    trhs_pkg::cmd_t cmd;
    trhs_pkg::sts_t sts;

    trhs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    trhs_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .torque_milli (torque_milli),
        .hold_ms      (hold_ms),
        .payload      (payload),
        .phase_after  (phase_after),
        .last_of_run  (last_of_run)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");

    a_zero_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_run) |=>
        (out_valid && last_of_run && phase_after == trhs_pkg::PH_IDLE))
        else $error("hold expiry not followed by zero frame");

    a_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase_after == trhs_pkg::PH_IDLE) |->
        (payload == trhs_pkg::PAYLOAD_ALL))
        else $error("idle frame carries torque");
`endif

endmodule

FILE: bench/torque_ramp_hold_sequencer_tb.sv
// Self-checking testbench for the torque ramp/hold command sequencer.
module torque_ramp_hold_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESET_CYCLES    = 12;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 80;
    localparam int unsigned QUIET_LIMIT     = 200000;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned RUN_CAP         = 300;
    localparam int unsigned IDLE_PCT        = 83;
    localparam int unsigned BOTH_PCT        = 36;

    typedef struct packed {
        logic        kind;
        logic [15:0] torque;
        logic [15:0] hold;
    } request_t;

    typedef struct packed {
        logic [63:0] payload;
        logic [1:0]  phase;
        logic        last;
    } frame_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_we       = 1'b0;
    logic [trhs_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [trhs_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                            in_valid     = 1'b0;
    logic                            in_ready;
    logic                            req_type     = trhs_pkg::REQ_TICK;
    logic [15:0]                     torque_milli = '0;
    logic [15:0]                     hold_ms      = '0;
    logic                            out_valid;
    logic                            out_ready    = 1'b0;
    logic [63:0]                     payload;
    logic [1:0]                      phase_after;
    logic                            last_of_run;

    request_t    requests_pending[$];
    frame_t      frames_due[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        recv_held      = 1'b0;
    event        hold_off_kick;

    int unsigned mismatches     = 0;
    int unsigned requests_taken = 0;
    int unsigned frames_checked = 0;
    int unsigned runs_ended     = 0;
    int unsigned settings_used  = 0;

    // Sequencer copy: registers start at their reset values
    logic [15:0]                    m_ramp_ms      = 16'd5000;
    logic [7:0]                     m_tx_period    = 8'd10;
    logic [15:0]                    m_torque_limit = 16'd8000;
    logic [15:0]                    m_hold_limit   = 16'd30000;
    logic [15:0]                    m_raw_offset   = 16'd32127;
    logic [7:0]                     m_res_div      = 8'd15;
    trhs_pkg::phase_t               m_phase        = trhs_pkg::PH_IDLE;
    logic [trhs_pkg::ELAPSED_W-1:0] m_elapsed      = '0;
    logic [trhs_pkg::SINCE_W-1:0]   m_since        = '0;
    logic                           m_forced       = 1'b0;
    logic [15:0]                    m_target       = '0;
    logic [15:0]                    m_hold_len     = '0;

    torque_ramp_hold_sequencer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .torque_milli (torque_milli),
        .hold_ms      (hold_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload      (payload),
        .phase_after  (phase_after),
        .last_of_run  (last_of_run)
    );

    always #10 clk = ~clk;

    // Frame for the command num/den milli-Nm; command zero or raw overflow leaves 0xFFFF
    function automatic logic [63:0] encode_torque(input logic [31:0] num, input logic [15:0] den);
        logic [31:0] scale;
        logic [31:0] raw;
        if (num == 0)
            return trhs_pkg::PAYLOAD_ALL;
        scale = 32'(den) * 32'((m_res_div == 8'd0) ? 8'd1 : m_res_div);
        raw   = num / scale + 32'(m_raw_offset);
        if (raw > 32'hFFFF)
            return trhs_pkg::PAYLOAD_ALL;
        return {trhs_pkg::PAYLOAD_HI, raw[15:0], trhs_pkg::PAYLOAD_LO};
    endfunction

    function automatic void expect_frame(input logic [63:0] bits, input trhs_pkg::phase_t ph,
                                         input logic last);
        frame_t f;
        f.payload = bits;
        f.phase   = ph;
        f.last    = last;
        frames_due.push_back(f);
    endfunction

    function automatic void advance_sequencer(input request_t rq);
        logic [15:0] span;
        logic [15:0] done_ms;
        logic        ramp_over;
        logic [63:0] frame_bits;
        if (rq.kind == trhs_pkg::REQ_TRIGGER)
        begin
            m_target   = (rq.torque < m_torque_limit) ? rq.torque : m_torque_limit;
            m_hold_len = (rq.hold < m_hold_limit) ? rq.hold : m_hold_limit;
            m_phase    = trhs_pkg::PH_RAMP;
            m_elapsed  = '0;
            m_since    = '0;
            m_forced   = 1'b1;
            return;
        end
        if (m_phase == trhs_pkg::PH_IDLE)
            return;
        if (m_forced || m_since >= m_tx_period)
        begin
            m_forced = 1'b0;
            m_since  = '0;
            if (m_phase == trhs_pkg::PH_RAMP)
            begin
                span       = (m_ramp_ms == 16'd0) ? 16'd1 : m_ramp_ms;
                ramp_over  = m_elapsed >= {1'b0, span};
                done_ms    = ramp_over ? span : m_elapsed[15:0];
                frame_bits = encode_torque(32'(m_target) * 32'(done_ms), span);
                if (ramp_over)
                begin
                    m_phase   = trhs_pkg::PH_HOLD;
                    m_elapsed = '0;
                end
                expect_frame(frame_bits, m_phase, 1'b1);
            end
            else
            begin
                frame_bits = encode_torque(32'(m_target), 16'd1);
                if (m_elapsed >= {1'b0, m_hold_len})
                begin
                    // hold expiry: target frame, then the zero frame closes the run
                    expect_frame(frame_bits, trhs_pkg::PH_HOLD, 1'b0);
                    expect_frame(trhs_pkg::PAYLOAD_ALL, trhs_pkg::PH_IDLE, 1'b1);
                    m_phase = trhs_pkg::PH_IDLE;
                    return;
                end
                expect_frame(frame_bits, trhs_pkg::PH_HOLD, 1'b1);
            end
        end
        if (m_elapsed != trhs_pkg::ELAPSED_MAX)
            m_elapsed = m_elapsed + 1'b1;
        if (m_since != trhs_pkg::SINCE_MAX)
            m_since = m_since + 1'b1;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] frame %0d %s: expected %h, got %h", $time, frames_checked, what,
                     want, got);
    endfunction

    function automatic void queue_request(input logic kind, input logic [15:0] torque,
                                          input logic [15:0] hold);
        request_t rq;
        rq.kind   = kind;
        rq.torque = torque;
        rq.hold   = hold;
        requests_pending.push_back(rq);
    endfunction

    function automatic logic [15:0] pick_torque();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_hold();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    // Runs of a trigger plus enough ticks to reach the zero frame unless RUN_CAP limits them,
    // some cut short so the next trigger restarts a running sequence.
    task automatic queue_runs(input int unsigned count);
        int unsigned queued;
        int unsigned len;
        logic [15:0] hold;
        logic [15:0] eff_hold;
        queued = 0;
        while (queued < count)
        begin
            hold     = pick_hold();
            eff_hold = (hold < m_hold_limit) ? hold : m_hold_limit;
            len      = m_ramp_ms + eff_hold + 2 * m_tx_period + 4;
            if (len > RUN_CAP)
                len = RUN_CAP;
            if ($urandom_range(4) == 0)
                len = $urandom_range(0, len);
            queue_request(trhs_pkg::REQ_TRIGGER, pick_torque(), hold);
            repeat (len)
                queue_request(trhs_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
            repeat ($urandom_range(0, 3))
                queue_request(trhs_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
            queued += 1 + len;
        end
    endtask

    task automatic write_reg(input logic [trhs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [trhs_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            trhs_pkg::CFG_RAMP_MS:      m_ramp_ms      = val;
            trhs_pkg::CFG_TX_PERIOD_MS: m_tx_period    = val[7:0];
            trhs_pkg::CFG_TORQUE_LIMIT: m_torque_limit = val;
            trhs_pkg::CFG_HOLD_LIMIT:   m_hold_limit   = val;
            trhs_pkg::CFG_RAW_OFFSET:   m_raw_offset   = val;
            trhs_pkg::CFG_RES_DIVISOR:  m_res_div      = val[7:0];
            default:                    ;
        endcase
    endtask

    // 8-bit registers get junk in the upper data bits
    task automatic configure(input logic [15:0] ramp, input logic [7:0] period,
                             input logic [15:0] tlim, input logic [15:0] hlim,
                             input logic [15:0] offset, input logic [7:0] divisor);
        write_reg(trhs_pkg::CFG_RAMP_MS, ramp);
        write_reg(trhs_pkg::CFG_TX_PERIOD_MS, {8'($urandom), period});
        write_reg(trhs_pkg::CFG_TORQUE_LIMIT, tlim);
        write_reg(trhs_pkg::CFG_HOLD_LIMIT, hlim);
        write_reg(trhs_pkg::CFG_RAW_OFFSET, offset);
        write_reg(trhs_pkg::CFG_RES_DIVISOR, {8'($urandom), divisor});
        @(negedge clk);
        settings_used++;
    endtask

    task automatic wait_quiet();
        int unsigned guard;
        guard = 0;
        while ((requests_pending.size() != 0 || in_valid || frames_due.size() != 0)
               && guard < QUIET_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_feed
        request_t rq;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            req_type     <= trhs_pkg::REQ_TICK;
            torque_milli <= '0;
            hold_ms      <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rq.kind   = req_type;
                rq.torque = torque_milli;
                rq.hold   = hold_ms;
                advance_sequencer(rq);
                requests_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    rq = requests_pending.pop_front();
                    in_valid     <= 1'b1;
                    req_type     <= rq.kind;
                    torque_milli <= rq.torque;
                    hold_ms      <= rq.hold;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : frame_sink
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !recv_held && ($urandom_range(99) >= recv_stall_pct);
    end

    always
    begin : hold_off_timer
        @(hold_off_kick);
        @(negedge clk);
        recv_held = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        recv_held = 1'b0;
    end

    always @(posedge clk)
    begin : frame_check
        frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            frames_checked++;
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] frame %0d with none expected: payload %h phase %0d last %b",
                             $time, frames_checked, payload, phase_after, last_of_run);
            end
            else
            begin
                want = frames_due.pop_front();
                if (payload !== want.payload)
                    flag_mismatch("payload", want.payload, payload);
                if (phase_after !== want.phase)
                    flag_mismatch("phase_after", 64'(want.phase), 64'(phase_after));
                if (last_of_run !== want.last)
                    flag_mismatch("last_of_run", 64'(want.last), 64'(last_of_run));
                if (want.phase == trhs_pkg::PH_IDLE)
                    runs_ended++;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned lap;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: idle tick, clamped trigger, forced first frame, paced frame, restart
        queue_request(trhs_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF);
        queue_request(trhs_pkg::REQ_TRIGGER, 16'hFFFF, 16'hFFFF);
        repeat (12)
            queue_request(trhs_pkg::REQ_TICK, 16'h0000, 16'hFFFF);
        queue_request(trhs_pkg::REQ_TRIGGER, 16'h0000, 16'h0000);
        queue_request(trhs_pkg::REQ_TICK, 16'hA5A5, 16'h5A5A);
        wait_quiet();

        // Zero ramp, zero divisor, zero period, zero hold limit, maximum offset
        configure(16'd0, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd0);
        queue_request(trhs_pkg::REQ_TRIGGER, 16'd0, 16'd7);
        repeat (4)
            queue_request(trhs_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
        queue_request(trhs_pkg::REQ_TRIGGER, 16'hFFFF, 16'hFFFF);
        repeat (3)
            queue_request(trhs_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
        wait_quiet();

        configure(16'd20, 8'd3, 16'd8000, 16'd30, 16'd32127, 8'd15);
        queue_runs(150);
        wait_quiet();

        // Long receiver hold-off with the sender streaming: input must back up
        configure(16'd10, 8'd0, 16'd8000, 16'd20, 16'd32127, 8'd15);
        queue_request(trhs_pkg::REQ_TRIGGER, pick_torque(), 16'd20);
        repeat (60)
            queue_request(trhs_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
        -> hold_off_kick;
        wait_quiet();

        configure(16'd1, 8'd1, 16'hFFFF, 16'hFFFF, 16'd0, 8'd1);
        send_idle_pct = IDLE_PCT;
        queue_runs(120);
        wait_quiet();

        configure(16'hFFFF, 8'd2, 16'hFFFF, 16'd0, 16'd0, 8'd1);
        send_idle_pct  = 0;
        recv_stall_pct = IDLE_PCT;
        queue_runs(150);
        wait_quiet();

        configure(16'd8, 8'd255, 16'd0, 16'd300, 16'd40000, 8'd255);
        send_idle_pct  = BOTH_PCT;
        recv_stall_pct = BOTH_PCT;
        queue_runs(100);
        wait_quiet();

        for (lap = 0; lap < 3; lap++)
        begin
            configure(16'($urandom_range(1, 40)), 8'($urandom_range(0, 6)), 16'($urandom),
                      16'($urandom_range(0, 60)), 16'($urandom), 8'($urandom));
            case ($urandom_range(3))
                0:       begin send_idle_pct = 0;        recv_stall_pct = 0;        end
                1:       begin send_idle_pct = IDLE_PCT; recv_stall_pct = 0;        end
                2:       begin send_idle_pct = 0;        recv_stall_pct = IDLE_PCT; end
                default: begin send_idle_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
            endcase
            queue_runs(60);
            wait_quiet();
        end

        if (frames_due.size() != 0)
        begin
            $display("%0d expected frames never arrived", frames_due.size());
            mismatches += frames_due.size();
        end
        $display("Covered %0d items in, %0d frames checked, %0d runs closed by a zero frame,",
                 requests_taken, frames_checked, runs_ended);
        $display("over %0d register settings with idle, stalled and backed-up handshakes.",
                 settings_used);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
